// ===== rtl/core/mafi_pkg.sv =====
// ----------------------------------------------------------------------------
// Motion-adaptive field interpolator package
// Shared constants, register map, configuration record and the stage records
// that travel down the five-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mafi_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int COEF_SHIFT = 13;

    localparam int PIX_W     = 16;
    localparam int IN_DATA_W = 304;
    localparam int IN_USER_W = 2;
    localparam int ADDR_W    = 5;
    localparam int R_W       = 36;

    localparam logic [1:0] MODE_LINE     = 2'd0;
    localparam logic [1:0] MODE_EDGE_CHK = 2'd1;

    localparam logic [2:0] REG_PEAK      = 3'd0;
    localparam logic [2:0] REG_USE_EXT   = 3'd1;
    localparam logic [2:0] REG_LF_CENTER = 3'd2;
    localparam logic [2:0] REG_LF_OUTER  = 3'd3;
    localparam logic [2:0] REG_HF_CENTER = 3'd4;
    localparam logic [2:0] REG_HF_NEAR   = 3'd5;
    localparam logic [2:0] REG_HF_FAR    = 3'd6;
    localparam logic [2:0] REG_SPATIAL   = 3'd7;

    localparam logic [15:0] RST_PEAK      = 16'd255;
    localparam logic [15:0] RST_LF_CENTER = 16'd4309;
    localparam logic [15:0] RST_LF_OUTER  = 16'd213;
    localparam logic [15:0] RST_HF_CENTER = 16'd5570;
    localparam logic [15:0] RST_HF_NEAR   = 16'd3801;
    localparam logic [15:0] RST_HF_FAR    = 16'd1016;
    localparam logic [31:0] RST_SPATIAL   = 32'd64295893;

    localparam logic signed [17:0] PIX_MAX = 18'((1 << PIXEL_BITS) - 1);

    typedef struct packed {
        logic [15:0] peak;
        logic        use_ext;
        logic [15:0] lf_center;
        logic [15:0] lf_outer;
        logic [15:0] hf_center;
        logic [15:0] hf_near;
        logic [15:0] hf_far;
        logic [15:0] sp_near;
        logic [15:0] sp_far;
    } cfg_t;

    typedef struct packed {
        logic               is_line;
        logic               chk;
        logic [15:0]        d;
        logic [15:0]        td0;
        logic [15:0]        td1;
        logic [15:0]        td2;
        logic signed [16:0] dc;
        logic signed [16:0] de;
        logic signed [16:0] b;
        logic signed [16:0] f;
        logic [15:0]        abs_ce;
        logic [15:0]        edge_avg;
        logic [16:0]        sum_ctr;
        logic [17:0]        sum_near;
        logic [17:0]        sum_far;
        logic [16:0]        sum_c;
        logic [16:0]        sum_c3;
        logic [15:0]        ext;
    } stg1_t;

    typedef struct packed {
        logic        is_line;
        logic        tdz;
        logic        sel_hf;
        logic [15:0] d;
        logic [15:0] diff;
        logic [15:0] edge_avg;
        logic [15:0] ext;
        logic [32:0] p_hfc;
        logic [33:0] p_hfn;
        logic [33:0] p_hff;
        logic [32:0] p_lfc;
        logic [32:0] p_lfo;
        logic [32:0] p_sn;
        logic [32:0] p_sf;
    } stg2_t;

    typedef struct packed {
        logic               is_line;
        logic               tdz;
        logic               sel_hf;
        logic [15:0]        d;
        logic [15:0]        edge_avg;
        logic [15:0]        ext;
        logic signed [35:0] hf;
        logic signed [33:0] lf;
        logic signed [33:0] spat;
        logic signed [17:0] lo_b;
        logic signed [17:0] hi_b;
    } stg3_t;

    typedef struct packed {
        logic                  is_line;
        logic                  tdz;
        logic [15:0]           d;
        logic signed [R_W-1:0] r;
        logic signed [17:0]    lo_b;
        logic signed [17:0]    hi_b;
    } stg4_t;

endpackage

`default_nettype wire

// ===== rtl/core/mafi_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Register file behind the APB-style port; reads return the stored values.
// ----------------------------------------------------------------------------
`default_nettype none

module mafi_regs
    import mafi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peak      <= RST_PEAK;
            cfg_reg.use_ext   <= 1'b0;
            cfg_reg.lf_center <= RST_LF_CENTER;
            cfg_reg.lf_outer  <= RST_LF_OUTER;
            cfg_reg.hf_center <= RST_HF_CENTER;
            cfg_reg.hf_near   <= RST_HF_NEAR;
            cfg_reg.hf_far    <= RST_HF_FAR;
            cfg_reg.sp_near   <= RST_SPATIAL[15:0];
            cfg_reg.sp_far    <= RST_SPATIAL[31:16];
        end
        else if (wr_en)
        begin
            case (idx)
                REG_PEAK:      cfg_reg.peak      <= pwdata[15:0];
                REG_USE_EXT:   cfg_reg.use_ext   <= pwdata[0];
                REG_LF_CENTER: cfg_reg.lf_center <= pwdata[15:0];
                REG_LF_OUTER:  cfg_reg.lf_outer  <= pwdata[15:0];
                REG_HF_CENTER: cfg_reg.hf_center <= pwdata[15:0];
                REG_HF_NEAR:   cfg_reg.hf_near   <= pwdata[15:0];
                REG_HF_FAR:    cfg_reg.hf_far    <= pwdata[15:0];
                REG_SPATIAL:
                begin
                    cfg_reg.sp_near <= pwdata[15:0];
                    cfg_reg.sp_far  <= pwdata[31:16];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PEAK:      prdata = {16'd0, cfg_reg.peak};
            REG_USE_EXT:   prdata = {31'd0, cfg_reg.use_ext};
            REG_LF_CENTER: prdata = {16'd0, cfg_reg.lf_center};
            REG_LF_OUTER:  prdata = {16'd0, cfg_reg.lf_outer};
            REG_HF_CENTER: prdata = {16'd0, cfg_reg.hf_center};
            REG_HF_NEAR:   prdata = {16'd0, cfg_reg.hf_near};
            REG_HF_FAR:    prdata = {16'd0, cfg_reg.hf_far};
            REG_SPATIAL:   prdata = {cfg_reg.sp_far, cfg_reg.sp_near};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/mafi_front.sv =====
// ----------------------------------------------------------------------------
// Front stage
// Unpacks the tap column and registers the averages, tap sums and
// absolute temporal and spatial differences.
// ----------------------------------------------------------------------------
`default_nettype none

module mafi_front
    import mafi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_DATA_W-1:0] in_data,
    input  logic [IN_USER_W-1:0] in_user,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stg1_t                out_stage
);

    logic        valid_reg;
    stg1_t       stage_reg;
    stg1_t       stage_next;
    logic [15:0] p2, n2, p2a2, p2b2, n2a2, n2b2, p2a4, p2b4, n2a4, n2b4;
    logic [15:0] pa, pb, na, nb, c, e, ca3, cb3;
    logic [16:0] sum_pn;
    logic [16:0] sum_ab;
    logic [16:0] sum_a2;
    logic [16:0] sum_b2;
    logic [16:0] sum_td1;
    logic [16:0] sum_td2;

    function automatic logic [15:0] abs_diff(input logic [15:0] x, input logic [15:0] y);
        abs_diff = (x > y) ? (x - y) : (y - x);
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    assign p2   = in_data[15:0];
    assign n2   = in_data[31:16];
    assign p2a2 = in_data[47:32];
    assign p2b2 = in_data[63:48];
    assign n2a2 = in_data[79:64];
    assign n2b2 = in_data[95:80];
    assign p2a4 = in_data[111:96];
    assign p2b4 = in_data[127:112];
    assign n2a4 = in_data[143:128];
    assign n2b4 = in_data[159:144];
    assign pa   = in_data[175:160];
    assign pb   = in_data[191:176];
    assign na   = in_data[207:192];
    assign nb   = in_data[223:208];
    assign c    = in_data[239:224];
    assign e    = in_data[255:240];
    assign ca3  = in_data[271:256];
    assign cb3  = in_data[287:272];

    always_comb
    begin
        sum_pn  = {1'b0, p2} + {1'b0, n2};
        sum_ab  = {1'b0, c} + {1'b0, e};
        sum_a2  = {1'b0, p2a2} + {1'b0, n2a2};
        sum_b2  = {1'b0, p2b2} + {1'b0, n2b2};
        sum_td1 = {1'b0, abs_diff(pa, c)} + {1'b0, abs_diff(pb, e)};
        sum_td2 = {1'b0, abs_diff(na, c)} + {1'b0, abs_diff(nb, e)};

        stage_next.is_line  = (in_user == MODE_LINE);
        stage_next.chk      = (in_user == MODE_LINE) || (in_user == MODE_EDGE_CHK);
        stage_next.d        = sum_pn[16:1];
        stage_next.td0      = abs_diff(p2, n2);
        stage_next.td1      = sum_td1[16:1];
        stage_next.td2      = sum_td2[16:1];
        stage_next.dc       = $signed({1'b0, sum_pn[16:1]}) - $signed({1'b0, c});
        stage_next.de       = $signed({1'b0, sum_pn[16:1]}) - $signed({1'b0, e});
        stage_next.b        = $signed({1'b0, sum_a2[16:1]}) - $signed({1'b0, c});
        stage_next.f        = $signed({1'b0, sum_b2[16:1]}) - $signed({1'b0, e});
        stage_next.abs_ce   = abs_diff(c, e);
        stage_next.edge_avg = sum_ab[16:1];
        stage_next.sum_ctr  = sum_pn;
        stage_next.sum_near = {1'b0, sum_a2} + {1'b0, sum_b2};
        stage_next.sum_far  = {2'b0, p2a4} + {2'b0, n2a4} + {2'b0, p2b4} + {2'b0, n2b4};
        stage_next.sum_c    = sum_ab;
        stage_next.sum_c3   = {1'b0, ca3} + {1'b0, cb3};
        stage_next.ext      = in_data[303:288];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mafi_mult.sv =====
// ----------------------------------------------------------------------------
// Product stage
// Registers the seven coefficient products and the temporal bound after
// the spatial check.
// ----------------------------------------------------------------------------
`default_nettype none

module mafi_mult
    import mafi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  stg1_t in_stage,
    output logic  out_valid,
    input  logic  out_ready,
    output stg2_t out_stage
);

    logic               valid_reg;
    stg2_t              stage_reg;
    stg2_t              stage_next;
    logic [15:0]        td;
    logic signed [16:0] hi_max;
    logic signed [16:0] lo_min;
    logic signed [17:0] td_s;
    logic signed [17:0] neg_hi;
    logic signed [17:0] diff_w;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    always_comb
    begin
        td = in_stage.td0 >> 1;
        if (in_stage.td1 > td)
        begin
            td = in_stage.td1;
        end
        if (in_stage.td2 > td)
        begin
            td = in_stage.td2;
        end

        hi_max = (in_stage.de > in_stage.dc) ? in_stage.de : in_stage.dc;
        if (((in_stage.b < in_stage.f) ? in_stage.b : in_stage.f) > hi_max)
        begin
            hi_max = (in_stage.b < in_stage.f) ? in_stage.b : in_stage.f;
        end
        lo_min = (in_stage.de < in_stage.dc) ? in_stage.de : in_stage.dc;
        if (((in_stage.b > in_stage.f) ? in_stage.b : in_stage.f) < lo_min)
        begin
            lo_min = (in_stage.b > in_stage.f) ? in_stage.b : in_stage.f;
        end

        td_s   = $signed({2'b0, td});
        neg_hi = -18'(hi_max);
        diff_w = (18'(lo_min) > td_s) ? 18'(lo_min) : td_s;
        if (neg_hi > diff_w)
        begin
            diff_w = neg_hi;
        end

        stage_next.is_line  = in_stage.is_line;
        stage_next.tdz      = (td == 16'd0);
        stage_next.sel_hf   = (in_stage.abs_ce > in_stage.td0);
        stage_next.d        = in_stage.d;
        stage_next.diff     = in_stage.chk ? diff_w[15:0] : td;
        stage_next.edge_avg = in_stage.edge_avg;
        stage_next.ext      = in_stage.ext;
        stage_next.p_hfc    = 33'(cfg.hf_center) * 33'(in_stage.sum_ctr);
        stage_next.p_hfn    = 34'(cfg.hf_near) * 34'(in_stage.sum_near);
        stage_next.p_hff    = 34'(cfg.hf_far) * 34'(in_stage.sum_far);
        stage_next.p_lfc    = 33'(cfg.lf_center) * 33'(in_stage.sum_c);
        stage_next.p_lfo    = 33'(cfg.lf_outer) * 33'(in_stage.sum_c3);
        stage_next.p_sn     = 33'(cfg.sp_near) * 33'(in_stage.sum_c);
        stage_next.p_sf     = 33'(cfg.sp_far) * 33'(in_stage.sum_c3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mafi_combine.sv =====
// ----------------------------------------------------------------------------
// Combine stages
// Sums the products into the blend and the spatial cubic, scales them and
// selects the candidate pixel, over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mafi_combine
    import mafi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  stg2_t in_stage,
    output logic  out_valid,
    input  logic  out_ready,
    output stg4_t out_stage
);

    logic                  s3_valid_reg;
    logic                  s4_valid_reg;
    logic                  s4_ready;
    stg3_t                 s3_reg;
    stg3_t                 s3_next;
    stg4_t                 s4_reg;
    stg4_t                 s4_next;
    logic signed [36:0]    acc;
    logic signed [R_W-1:0] i1;
    logic signed [R_W-1:0] i2;
    logic signed [R_W-1:0] edge_r;

    assign s4_ready  = !s4_valid_reg || out_ready;
    assign in_ready  = !s3_valid_reg || s4_ready;
    assign out_valid = s4_valid_reg;
    assign out_stage = s4_reg;

    always_comb
    begin
        s3_next.is_line  = in_stage.is_line;
        s3_next.tdz      = in_stage.tdz;
        s3_next.sel_hf   = in_stage.sel_hf;
        s3_next.d        = in_stage.d;
        s3_next.edge_avg = in_stage.edge_avg;
        s3_next.ext      = in_stage.ext;
        s3_next.hf       = $signed({3'b0, in_stage.p_hfc}) - $signed({2'b0, in_stage.p_hfn})
                         + $signed({2'b0, in_stage.p_hff});
        s3_next.lf       = $signed({1'b0, in_stage.p_lfc}) - $signed({1'b0, in_stage.p_lfo});
        s3_next.spat     = $signed({1'b0, in_stage.p_sn}) - $signed({1'b0, in_stage.p_sf});
        s3_next.lo_b     = $signed({2'b0, in_stage.d}) - $signed({2'b0, in_stage.diff});
        s3_next.hi_b     = $signed({2'b0, in_stage.d}) + $signed({2'b0, in_stage.diff});
    end

    always_comb
    begin
        acc    = 37'(s3_reg.hf >>> 2) + 37'(s3_reg.lf);
        i1     = R_W'(acc >>> COEF_SHIFT);
        i2     = cfg.use_ext ? $signed(R_W'({1'b0, s3_reg.ext}))
                             : R_W'(s3_reg.spat >>> COEF_SHIFT);
        edge_r = cfg.use_ext ? $signed(R_W'({1'b0, s3_reg.ext}))
                             : $signed(R_W'({1'b0, s3_reg.edge_avg}));

        s4_next.is_line = s3_reg.is_line;
        s4_next.tdz     = s3_reg.tdz;
        s4_next.d       = s3_reg.d;
        s4_next.r       = s3_reg.is_line ? (s3_reg.sel_hf ? i1 : i2) : edge_r;
        s4_next.lo_b    = s3_reg.lo_b;
        s4_next.hi_b    = s3_reg.hi_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s3_valid_reg <= in_valid;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s3_reg <= s3_next;
        end
        if (s4_ready)
        begin
            s4_reg <= s4_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mafi_clamp.sv =====
// ----------------------------------------------------------------------------
// Clamp stage
// Bounds the candidate by the temporal window and, on line rows, the peak,
// uses d if td is zero, clamps to the pixel range, holds the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module mafi_clamp
    import mafi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  stg4_t            in_stage,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] pixel
);

    logic                  valid_reg;
    logic [PIX_W-1:0]      pixel_reg;
    logic [PIX_W-1:0]      pixel_next;
    logic signed [R_W-1:0] lo_w;
    logic signed [R_W-1:0] hi_w;
    logic signed [R_W-1:0] r_win;
    logic signed [17:0]    r_nar;
    logic signed [17:0]    peak_s;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign pixel     = pixel_reg;

    always_comb
    begin
        lo_w   = R_W'(in_stage.lo_b);
        hi_w   = R_W'(in_stage.hi_b);
        peak_s = $signed({2'b0, cfg.peak});
        r_win  = (in_stage.r < lo_w) ? lo_w : in_stage.r;
        if (r_win > hi_w)
        begin
            r_win = hi_w;
        end
        r_nar = 18'(r_win);
        if (in_stage.is_line)
        begin
            if (r_nar < 18'sd0)
            begin
                r_nar = 18'sd0;
            end
            if (r_nar > peak_s)
            begin
                r_nar = peak_s;
            end
        end
        if (in_stage.tdz)
        begin
            r_nar = $signed({2'b0, in_stage.d});
        end
        if (r_nar < 18'sd0)
        begin
            r_nar = 18'sd0;
        end
        if (r_nar > PIX_MAX)
        begin
            r_nar = PIX_MAX;
        end
        pixel_next = r_nar[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            pixel_reg <= pixel_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/motion_adaptive_field_interpolator.sv =====
// ----------------------------------------------------------------------------
// Motion-adaptive field interpolator
// Computes one missing-line pixel from a column of taps in five fields.
//
//   Channel   Direction  Signals                     Word
//   s_axis    in         tvalid tready tdata tuser   tap column, row mode
//   m_axis    out        tvalid tready tdata         interpolated pixel
//   apb       in/out     psel penable pwrite paddr   eight config registers
//
// One word is accepted per cycle while no stage is stalled; a result leaves
// through five register stages (front, products, two combine stages,
// clamp). Each stage has its own valid bit and loads when it is empty or
// the next stage loads, so bubbles close up during stalls.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_adaptive_field_interpolator
    import mafi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // older_center, newer_center, older_near_pair, newer_near_pair,
    // older_far_pair, newer_far_pair, previous_pair, following_pair,
    // current_near_pair, current_far_pair, external_interp
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // row_mode
    input  logic [IN_USER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pixel_out
    output logic [PIX_W-1:0]     m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    cfg_t  cfg;
    stg1_t st1;
    stg2_t st2;
    stg4_t st4;
    logic  v1, v2, v4;
    logic  r2, r3, r5;

    mafi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mafi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (v1),
        .out_ready (r2),
        .out_stage (st1)
    );

    mafi_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (v1),
        .in_ready  (r2),
        .in_stage  (st1),
        .out_valid (v2),
        .out_ready (r3),
        .out_stage (st2)
    );

    mafi_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (v2),
        .in_ready  (r3),
        .in_stage  (st2),
        .out_valid (v4),
        .out_ready (r5),
        .out_stage (st4)
    );

    mafi_clamp u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (v4),
        .in_ready  (r5),
        .in_stage  (st4),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .pixel     (m_axis_tdata)
    );

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v1 && v2 && v4 && m_axis_tvalid && !m_axis_tready))
        else $error("Input blocked while the pipeline has room.");

    a_accept_fills_front: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1)
        else $error("Accepted word did not reach the front stage.");

    a_front_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (v1 && r2) |=> v2)
        else $error("Front stage word was dropped.");

    a_out_drop_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("Output word withdrawn before it was taken.");

endmodule

`default_nettype wire
